// ----- src/csb_pkg.sv -----
package csb_pkg;

	localparam int MAX_DIM_DEF = 1024;
	localparam int HIT_LEVEL = 150;
	localparam int SUM_W = 32;
	localparam int CNT_W = 21;
	localparam int POS_CMP_W = 13;
	localparam int ORG_W = 12;
	localparam int SIZE_W = 11;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_ADDR_W = 2;
	localparam int CTR_W = 10;
	localparam int NEW_W = 14;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_X = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_Y = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_WIDTH = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_START_COL,
		ST_WAIT_COL,
		ST_START_ROW,
		ST_WAIT_ROW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [SUM_W-1:0] col_sum;
		logic [SUM_W-1:0] row_sum;
		logic [CNT_W-1:0] hits;
	} acc_sums_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
		input int unsigned max_dim);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > max_dim) begin
			r = SIZE_W'(max_dim);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Origin minus half the size plus the centre, truncated toward zero.
	function automatic logic [NEW_W-1:0] recentre(input logic [ORG_W-1:0] origin,
		input logic [SIZE_W-1:0] size, input logic [SUM_W-1:0] centre);
		logic signed [35:0] twice;
		logic signed [35:0] half;
		twice = $signed({23'b0, origin, 1'b0}) - $signed({25'b0, size})
			+ $signed({3'b0, centre, 1'b0});
		if (twice < 0 && twice[0]) begin
			half = (twice + 36'sd1) >>> 1;
		end else begin
			half = twice >>> 1;
		end
		return half[NEW_W-1:0];
	endfunction

endpackage

// ----- src/csb_accum.sv -----
module csb_accum #(
	parameter int MAX_DIM = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic                    clear,
	input  logic [7:0]              blue,
	input  logic [7:0]              green,
	input  logic [7:0]              red,
	input  logic [10:0]             eff_w,
	input  logic [10:0]             eff_h,
	output csb_pkg::acc_sums_t      sums,
	output logic                    win_end
);
	import csb_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);

	logic [POS_W-1:0] col_pos_q;
	logic [POS_W-1:0] row_pos_q;
	acc_sums_t        sums_q;
	logic             hit;
	logic             row_end;

	assign hit = (green < 8'(HIT_LEVEL)) && (red > 8'(HIT_LEVEL)) && (blue > 8'(HIT_LEVEL));
	assign row_end = (POS_CMP_W'(col_pos_q) + POS_CMP_W'(1)) >= POS_CMP_W'(eff_w);
	assign win_end = row_end && ((POS_CMP_W'(row_pos_q) + POS_CMP_W'(1)) >= POS_CMP_W'(eff_h));
	assign sums = sums_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			sums_q.col_sum <= '0;
			sums_q.row_sum <= '0;
			sums_q.hits <= CNT_W'(1);
		end else if (clear) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			sums_q.col_sum <= '0;
			sums_q.row_sum <= '0;
			sums_q.hits <= CNT_W'(1);
		end else if (take) begin
			if (hit) begin
				sums_q.col_sum <= sums_q.col_sum + SUM_W'(col_pos_q);
				sums_q.row_sum <= sums_q.row_sum + SUM_W'(row_pos_q);
				if (sums_q.hits != CNT_MAX) begin
					sums_q.hits <= sums_q.hits + CNT_W'(1);
				end
			end
			if (!win_end) begin
				if (row_end) begin
					col_pos_q <= '0;
					row_pos_q <= row_pos_q + POS_W'(1);
				end else begin
					col_pos_q <= col_pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

// ----- src/csb_divider.sv -----
module csb_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csb_pkg::SUM_W-1:0]   dividend,
	input  logic [csb_pkg::CNT_W-1:0]   divisor,
	output logic                        busy,
	output logic                        done,
	output logic [csb_pkg::SUM_W-1:0]   quotient
);
	import csb_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W+1:0]  diff;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff = {1'b0, trial} - {2'b0, div_q};
	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- src/color_blob_centroid_unit.sv -----
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    one pixel
// m_*       out        m_tvalid / m_tready    one centroid result per window
// cfg_*     in         cfg_valid / cfg_ready  register index and write data
//
// A pixel that does not close the window leaves the block in its accumulate state, ready for the next pixel.
// The last pixel of a window then passes through two runs of the shared restoring divider, each
// a start, 32 quotient steps and the taking of the quotient, and then the emit state loads the
// result register.
// Reset clears the window position, the coordinate sums and the handshake state, sets the hit
// count to one, and loads the register defaults.
// A result still waiting on m_tready holds the next result in the emit state until it is taken.
module color_blob_centroid_unit #(
	parameter int MAX_DIM = csb_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// blue [7:0], green [15:8], red [23:16]
	input  logic [23:0]                      s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// center_col [9:0], center_row [19:10], hit_total [40:20], new_x [54:41],
	// new_y [68:55], zero [71:69]
	output logic [71:0]                      m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [csb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [csb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import csb_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [ORG_W-1:0]  window_x_q;
	logic [ORG_W-1:0]  window_y_q;
	logic [SIZE_W-1:0] window_width_q;
	logic [SIZE_W-1:0] window_height_q;
	logic [SIZE_W-1:0] eff_w;
	logic [SIZE_W-1:0] eff_h;
	acc_sums_t         sums;
	logic              win_end;
	logic              take;
	logic              clear;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [SUM_W-1:0]  dividend;
	logic [SUM_W-1:0]  quotient;
	logic [SUM_W-1:0]  col_quo_q;
	logic              m_tvalid_q;
	logic [71:0]       m_tdata_q;
	logic              load_out;

	assign eff_w = eff_size(window_width_q, MAX_DIM);
	assign eff_h = eff_size(window_height_q, MAX_DIM);
	assign take = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q <= ORG_W'(300);
			window_y_q <= ORG_W'(200);
			window_width_q <= SIZE_W'(100);
			window_height_q <= SIZE_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_WINDOW_X: window_x_q <= cfg_data;
				REG_WINDOW_Y: window_y_q <= cfg_data;
				REG_WINDOW_WIDTH: window_width_q <= cfg_data[SIZE_W-1:0];
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	csb_accum #(
		.MAX_DIM(MAX_DIM)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.clear(clear),
		.blue(s_tdata[7:0]),
		.green(s_tdata[15:8]),
		.red(s_tdata[23:16]),
		.eff_w(eff_w),
		.eff_h(eff_h),
		.sums(sums),
		.win_end(win_end)
	);

	csb_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(sums.hits),
		.busy(div_busy),
		.done(div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		div_start = 1'b0;
		dividend = sums.col_sum;
		load_out = 1'b0;
		clear = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				s_tready = 1'b1;
				if (s_tvalid && win_end) begin
					state_d = ST_START_COL;
				end
			end
			ST_START_COL: begin
				div_start = 1'b1;
				state_d = ST_WAIT_COL;
			end
			ST_WAIT_COL: begin
				if (div_done) begin
					state_d = ST_START_ROW;
				end
			end
			ST_START_ROW: begin
				div_start = 1'b1;
				dividend = sums.row_sum;
				state_d = ST_WAIT_ROW;
			end
			ST_WAIT_ROW: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					clear = 1'b1;
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT_COL && div_done) begin
			col_quo_q <= quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {3'b0,
				recentre(window_y_q, eff_h, quotient),
				recentre(window_x_q, eff_w, col_quo_q),
				sums.hits,
				quotient[CTR_W-1:0],
				col_quo_q[CTR_W-1:0]};
		end
	end

	a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !s_tready)
		else $error("pixel request accepted while the divider is busy");

	a_window_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && win_end) |=> !s_tready)
		else $error("block still ready after the last pixel of a window");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[40:20] != '0))
		else $error("result carries a zero hit total");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT_COL || state_q == ST_WAIT_ROW))
		else $error("divider finished outside a wait state");

endmodule
